### hdl/itoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digit positions for the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int DEC_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  // Digit shifter: BCD during conversion, left-aligned digits during output.
  localparam int SHIFT_W    = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] KIND_DEC  = 2'd0;
  localparam logic [1:0] KIND_BIN  = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic set_dec;
    logic shift;
    logic emit;
    logic emit_minus;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_one;
    logic top_zero;
  } dp_status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_A + 7'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/itoa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [1:0]           kind_i,
  input  wire logic                 neg_i,
  input  wire itoa_pkg::dp_status_t status_i,
  output itoa_pkg::ctl_cmd_t        cmd_o,
  output logic                      busy_o
);
  import itoa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && (kind_i != KIND_NONE)) begin
          if (kind_i == KIND_DEC) begin
            state_d = neg_i ? ST_SIGN : ST_DABBLE;
          end else begin
            state_d = ST_SKIP;
          end
        end
      end
      ST_SIGN: state_d = ST_DABBLE;
      ST_DABBLE: begin
        if (status_i.cnt_one) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!status_i.top_zero || status_i.cnt_one) begin
          state_d = status_i.cnt_one ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.cnt_one) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load = start_i && (kind_i != KIND_NONE);
      ST_SIGN: begin
        cmd_o.emit_minus = 1'b1;
        cmd_o.dabble     = 1'b1;
      end
      ST_DABBLE: begin
        cmd_o.dabble  = 1'b1;
        cmd_o.set_dec = status_i.cnt_one;
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (status_i.top_zero && !status_i.cnt_one) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      ST_EMIT: cmd_o.emit = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hdl/itoa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire itoa_pkg::ctl_cmd_t                  cmd_i,
  input  wire logic [1:0]                          kind_i,
  input  wire logic [itoa_pkg::VALUE_WIDTH-1:0]    value_i,
  output itoa_pkg::dp_status_t                     status_o,
  output logic                                     out_valid_o,
  output logic [6:0]                               char_code_o,
  output logic                                     last_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [SHIFT_W-1:0]     sh_q, sh_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   step4_q, step4_d;
  logic                   valid_q, valid_d;
  logic [6:0]             char_q, char_d;
  logic                   last_q, last_d;

  logic [VALUE_WIDTH-1:0] mag;
  logic [SHIFT_W-1:0]     bcd_adj;
  logic [SHIFT_W-1:0]     sh_next;
  logic [3:0]             top_digit;

  assign mag = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (sh_q[4*i +: 4] >= 4'd5) ? (sh_q[4*i +: 4] + 4'd3)
                                                   : sh_q[4*i +: 4];
    end
  end

  assign top_digit = step4_q ? sh_q[SHIFT_W-1 -: 4] : {3'b000, sh_q[SHIFT_W-1]};
  assign sh_next   = step4_q ? (sh_q << 4) : (sh_q << 1);

  assign status_o.cnt_one  = (cnt_q == CNT_W'(1));
  assign status_o.top_zero = (top_digit == 4'd0);

  always_comb begin
    bin_d   = bin_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    step4_d = step4_q;
    valid_d = cmd_i.emit || cmd_i.emit_minus;
    char_d  = cmd_i.emit_minus ? CHAR_MINUS : digit_char(top_digit);
    last_d  = cmd_i.emit && status_o.cnt_one;

    if (cmd_i.load) begin
      unique case (kind_i)
        KIND_BIN: begin
          sh_d    = SHIFT_W'(value_i) << (SHIFT_W - VALUE_WIDTH);
          cnt_d   = CNT_W'(VALUE_WIDTH);
          step4_d = 1'b0;
        end
        KIND_HEX: begin
          sh_d    = SHIFT_W'(HEX_W'(value_i)) << (SHIFT_W - HEX_W);
          cnt_d   = CNT_W'(HEX_DIGITS);
          step4_d = 1'b1;
        end
        default: begin
          bin_d   = mag;
          sh_d    = '0;
          cnt_d   = CNT_W'(VALUE_WIDTH);
          step4_d = 1'b1;
        end
      endcase
    end else if (cmd_i.dabble) begin
      sh_d  = {bcd_adj[SHIFT_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = bin_q << 1;
      cnt_d = cmd_i.set_dec ? CNT_W'(DEC_DIGITS) : (cnt_q - CNT_W'(1));
    end else if (cmd_i.shift || cmd_i.emit) begin
      sh_d  = sh_next;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    sh_q    <= sh_d;
    cnt_q   <= cnt_d;
    step4_q <= step4_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hdl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none

// Formats a signed integer as ASCII in decimal, binary or uppercase hex, one
// character per cycle on char_code_o with out_valid_o high for that single
// cycle and last_o marking the final character; the receiver cannot stall,
// so it must take every strobed character. Pulse start_i while busy_o is low
// to hand in an item; kind 3 is taken and yields nothing. Binary and hex load
// the word and then walk its digit positions (32 or 8), leading zeros being
// dropped one position a cycle. Decimal loads the magnitude and shifts its
// 32 bits through shift-and-add-3 binary-to-BCD conversion (the '-' is issued
// with the first shift step), then walks its BCD positions (10). Characters
// are registered from the state that makes them, so the last character of
// one item may overlap the next load.
module integer_to_ascii_formatter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       kind_i,
  input  wire logic signed [itoa_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                  out_valid_o,
  output logic [6:0]                            char_code_o,
  output logic                                  last_o
);
  import itoa_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  itoa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .neg_i    (value_i[VALUE_WIDTH-1]),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  itoa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o)
    else $error("character strobed right after last");

  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (out_valid_o && last_o))
    else $error("went idle without final character");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i != KIND_NONE)) |=> busy_o)
    else $error("accepted item did not start");

  a_no_char_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !$past(busy_o)) |-> !out_valid_o)
    else $error("character while idle");

endmodule

`default_nettype wire
